@@ hdl/cwm_pkg.sv @@
// Shared constants, register indexes and the arctangent table of the cylindrical warp.
`default_nettype none
package cwm_pkg;

  // Defaults of the top-level parameters.
  localparam int FocalFracBitsDef = 8;
  localparam int CordicStagesDef  = 16;

  // Coordinate width; it sets the address ports, so it is fixed here.
  localparam int CoordBits = 12;

  // Fixed field widths.
  localparam int AddrW = CoordBits;      // source/destination row and column
  localparam int DimW  = 13;             // width and height registers
  localparam int FocW  = 20;             // focal length, unsigned fixed point
  localparam int PixW  = 8;              // one color channel
  localparam int OffW  = CoordBits + 1;  // centered coordinate, signed
  localparam int QuotW = CoordBits;      // magnitude of the row offset

  localparam int GuardBits  = 8;
  localparam int AngleFrac  = 24;
  localparam int AngleTabN  = 24;
  localparam int AngleW     = 25;
  localparam int ZW         = 27;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 20;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL  = 2'd2;

  localparam logic [DimW-1:0] WidthRst  = 13'd640;
  localparam logic [DimW-1:0] HeightRst = 13'd480;
  localparam logic [FocW-1:0] FocalRst  = 20'd180224;

  // atan(2^-i) in radians, 24 fraction bits, rounded to nearest.
  function automatic logic [AngleW-1:0] atan_q24(input int idx);
    logic [AngleW-1:0] a;
    case (idx)
      0:       a = 25'd13176795;
      1:       a = 25'd7778716;
      2:       a = 25'd4110060;
      3:       a = 25'd2086331;
      4:       a = 25'd1047214;
      5:       a = 25'd524117;
      6:       a = 25'd262123;
      7:       a = 25'd131069;
      8:       a = 25'd65536;
      9:       a = 25'd32768;
      10:      a = 25'd16384;
      11:      a = 25'd8192;
      12:      a = 25'd4096;
      13:      a = 25'd2048;
      14:      a = 25'd1024;
      15:      a = 25'd512;
      16:      a = 25'd256;
      17:      a = 25'd128;
      18:      a = 25'd64;
      19:      a = 25'd32;
      20:      a = 25'd16;
      21:      a = 25'd8;
      22:      a = 25'd4;
      23:      a = 25'd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cwm_rot_cell.sv @@
// One cell of the angle/root chain: a CORDIC vectoring step and an integer square-root step.
`default_nettype none
module cwm_rot_cell #(
  parameter int CW      = 32,
  parameter int VW      = 41,
  parameter int IDX     = 0,
  parameter bit DO_ROT  = 1'b1,
  parameter bit DO_ROOT = 1'b1,
  parameter int ROOT_SH = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  cx_i,
  input  logic signed [CW-1:0]  cy_i,
  input  logic signed [cwm_pkg::ZW-1:0] z_i,
  input  logic [VW-1:0]         rem_i,
  input  logic [VW:0]           root_i,
  output logic                  valid_o,
  output logic signed [CW-1:0]  cx_o,
  output logic signed [CW-1:0]  cy_o,
  output logic signed [cwm_pkg::ZW-1:0] z_o,
  output logic [VW-1:0]         rem_o,
  output logic [VW:0]           root_o
);
  import cwm_pkg::*;

  localparam logic [VW:0] RootBit = (VW+1)'(1) << ROOT_SH;
  localparam logic signed [ZW-1:0] Ang = $signed(ZW'(atan_q24(IDX)));

  logic                 valid_q;
  logic signed [CW-1:0] cx_d, cx_q, cy_d, cy_q, dx, dy;
  logic signed [ZW-1:0] z_d, z_q;
  logic [VW-1:0]        rem_d, rem_q;
  logic [VW:0]          root_d, root_q, trial;

  always_comb begin
    dx = cy_i >>> IDX;
    dy = cx_i >>> IDX;
    cx_d = cx_i;
    cy_d = cy_i;
    z_d  = z_i;
    if (DO_ROT) begin
      if (!cy_i[CW-1]) begin
        cx_d = cx_i + dx;
        cy_d = cy_i - dy;
        z_d  = z_i + Ang;
      end else begin
        cx_d = cx_i - dx;
        cy_d = cy_i + dy;
        z_d  = z_i - Ang;
      end
    end
  end

  always_comb begin
    trial  = root_i + RootBit;
    rem_d  = rem_i;
    root_d = root_i;
    if (DO_ROOT) begin
      if ({1'b0, rem_i} >= trial) begin
        rem_d  = rem_i - trial[VW-1:0];
        root_d = (root_i >> 1) + RootBit;
      end else begin
        root_d = root_i >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    z_q    <= z_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign valid_o = valid_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign z_o     = z_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire

@@ hdl/cwm_div_cell.sv @@
// One cell of the restoring divider chain: settles one quotient bit.
`default_nettype none
module cwm_div_cell #(
  parameter int DW = 32,
  parameter int MW = 21,
  parameter int K  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [DW-1:0]               rem_i,
  input  logic [MW-1:0]               den_i,
  input  logic [cwm_pkg::QuotW-1:0]   quo_i,
  output logic                        valid_o,
  output logic [DW-1:0]               rem_o,
  output logic [MW-1:0]               den_o,
  output logic [cwm_pkg::QuotW-1:0]   quo_o
);
  import cwm_pkg::*;

  logic              valid_q;
  logic [DW-1:0]     trial, rem_d, rem_q;
  logic [MW-1:0]     den_q;
  logic [QuotW-1:0]  quo_d, quo_q;

  always_comb begin
    trial = DW'(den_i) << K;
    rem_d = rem_i;
    quo_d = quo_i;
    if (rem_i >= trial) begin
      rem_d    = rem_i - trial;
      quo_d[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_i;
    quo_q <= quo_d;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;

endmodule
`default_nettype wire

@@ hdl/cylindrical_warp_mapping.sv @@
// Top level of the cylindrical warp: config registers, front stages, cell chains, output stage.
// One source pixel enters on every clock at which start is high; busy is never raised.
// Each item passes the front stages, the chain of angle/root cells, twelve divider cells
// (one per bit of the row offset) and the output stage, and leaves with its result on
// the output ports for one cycle under out_valid_o. The receiver cannot stall the block.
// A chain cell does a CORDIC step while its index is below min(CORDIC_STAGES,24) and a
// square-root bit while below R, R being the square-root width (21 at the default
// FOCAL_FRAC_BITS). Configuration is taken at once; write it while no item is in flight.
`default_nettype none
module cylindrical_warp_mapping #(
  parameter int FOCAL_FRAC_BITS = cwm_pkg::FocalFracBitsDef,
  parameter int CORDIC_STAGES   = cwm_pkg::CordicStagesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cwm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cwm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [cwm_pkg::AddrW-1:0]      src_row_i,
  input  logic [cwm_pkg::AddrW-1:0]      src_col_i,
  input  logic [cwm_pkg::PixW-1:0]       pix_blue_i,
  input  logic [cwm_pkg::PixW-1:0]       pix_green_i,
  input  logic [cwm_pkg::PixW-1:0]       pix_red_i,
  output logic                           out_valid_o,
  output logic [cwm_pkg::AddrW-1:0]      dst_row_o,
  output logic [cwm_pkg::AddrW-1:0]      dst_col_o,
  output logic [cwm_pkg::PixW-1:0]       out_blue_o,
  output logic [cwm_pkg::PixW-1:0]       out_green_o,
  output logic [cwm_pkg::PixW-1:0]       out_red_o
);
  import cwm_pkg::*;

  // CORDIC datapath width: centered column scaled up, plus gain headroom.
  localparam int CyW  = OffW + FOCAL_FRAC_BITS + GuardBits;
  localparam int CxW  = FocW + GuardBits + 1;
  localparam int CW   = ((CyW > CxW) ? CyW : CxW) + 3;
  // Square-root radicand xp^2 * 2^(2F) + f^2 and its root.
  localparam int SqW  = 2 * (OffW - 1);
  localparam int RadA = SqW + 2 * FOCAL_FRAC_BITS;
  localparam int VW   = ((RadA > 2 * FocW) ? RadA : 2 * FocW) + 1;
  localparam int MW   = (VW + 1) / 2;
  localparam int NC   = (CORDIC_STAGES < AngleTabN) ? CORDIC_STAGES : AngleTabN;
  localparam int NR   = (NC > MW) ? NC : MW;
  // Row numerator f * |yp| and divider width.
  localparam int NW   = FocW + OffW - 1;
  localparam int DW   = (NW > MW + QuotW) ? NW : MW + QuotW;
  localparam int PW   = FocW + 1 + ZW;
  localparam int XSh  = FOCAL_FRAC_BITS + AngleFrac;
  localparam int XoW  = PW - XSh;
  localparam int SumW = 24;
  localparam int PixAll = 3 * PixW;
  localparam int SaW  = NW + 1 + PixAll;
  localparam int SbW  = PW + 2 + PixAll;
  localparam logic [AddrW-1:0] CMask = AddrW'((1 << CoordBits) - 1);
  localparam logic signed [SumW-1:0] CapV = SumW'((1 << CoordBits) - 1);

  // ---------------- configuration registers ----------------
  logic [DimW-1:0] width_q, height_q;
  logic [FocW-1:0] focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      focal_q  <= FocalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        CFG_FOCAL:  focal_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline takes an item every cycle.
  assign busy = 1'b0;

  logic [AddrW-1:0] whalf, hhalf;
  assign whalf = width_q[DimW-1:1];
  assign hhalf = height_q[DimW-1:1];

  // ---------------- stage 0: center the coordinates ----------------
  logic                   v0_q;
  logic signed [OffW-1:0] xp0_q, yp0_q;
  logic [PixAll-1:0]      pix0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    xp0_q  <= $signed({1'b0, src_col_i & CMask}) - $signed({1'b0, whalf});
    yp0_q  <= $signed({1'b0, src_row_i & CMask}) - $signed({1'b0, hhalf});
    pix0_q <= {pix_red_i, pix_green_i, pix_blue_i};
  end

  // ---------------- stage 1: products ----------------
  logic                   v1_q;
  logic signed [CW-1:0]   cx1_q, cy1_q;
  logic [SqW-1:0]         xsq1_q;
  logic [2*FocW-1:0]      fsq1_q;
  logic [NW-1:0]          num1_q;
  logic                   neg1_q;
  logic [PixAll-1:0]      pix1_q;
  logic signed [2*OffW-1:0] xsq_full;
  logic [OffW-1:0]        yp_abs;

  assign xsq_full = xp0_q * xp0_q;
  assign yp_abs   = yp0_q[OffW-1] ? OffW'(-yp0_q) : OffW'(yp0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cx1_q  <= $signed(CW'(focal_q) << GuardBits);
    cy1_q  <= CW'(xp0_q) <<< (FOCAL_FRAC_BITS + GuardBits);
    xsq1_q <= xsq_full[SqW-1:0];
    fsq1_q <= focal_q * focal_q;
    num1_q <= focal_q * yp_abs[OffW-2:0];
    neg1_q <= yp0_q[OffW-1];
    pix1_q <= pix0_q;
  end

  // ---------------- stage 2: radicand ----------------
  logic                 v2_q;
  logic signed [CW-1:0] cx2_q, cy2_q;
  logic [VW-1:0]        rad2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cx2_q  <= cx1_q;
    cy2_q  <= cy1_q;
    rad2_q <= (VW'(xsq1_q) << (2 * FOCAL_FRAC_BITS)) + VW'(fsq1_q);
  end

  // Side line carried past the angle/root chain.
  logic [SaW-1:0] side_a [NR+1];
  always_ff @(posedge clk_i) begin
    side_a[0] <= {num1_q, neg1_q, pix1_q};
  end

  // ---------------- angle / root chain ----------------
  logic                 rv   [NR+1];
  logic signed [CW-1:0] rcx  [NR+1];
  logic signed [CW-1:0] rcy  [NR+1];
  logic signed [ZW-1:0] rz   [NR+1];
  logic [VW-1:0]        rrem [NR+1];
  logic [VW:0]          rrt  [NR+1];

  assign rv[0]   = v2_q;
  assign rcx[0]  = cx2_q;
  assign rcy[0]  = cy2_q;
  assign rz[0]   = '0;
  assign rrem[0] = rad2_q;
  assign rrt[0]  = '0;

  for (genvar j = 0; j < NR; j++) begin : g_rot
    cwm_rot_cell #(
      .CW      (CW),
      .VW      (VW),
      .IDX     (j),
      .DO_ROT  (j < NC),
      .DO_ROOT (j < MW),
      .ROOT_SH ((j < MW) ? 2 * (MW - 1 - j) : 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv[j]),
      .cx_i    (rcx[j]),
      .cy_i    (rcy[j]),
      .z_i     (rz[j]),
      .rem_i   (rrem[j]),
      .root_i  (rrt[j]),
      .valid_o (rv[j+1]),
      .cx_o    (rcx[j+1]),
      .cy_o    (rcy[j+1]),
      .z_o     (rz[j+1]),
      .rem_o   (rrem[j+1]),
      .root_o  (rrt[j+1])
    );
    always_ff @(posedge clk_i) begin
      side_a[j+1] <= side_a[j];
    end
  end

  // ---------------- stage 3: column product ----------------
  logic                 v3_q;
  logic signed [PW-1:0] prod3;
  logic [MW-1:0]        m3_q;
  logic [NW-1:0]        num3;
  logic                 neg3;
  logic [PixAll-1:0]    pix3;

  // side_a[NR] is the tap aligned with the end of the chain
  assign {num3, neg3, pix3} = side_a[NR];
  assign prod3 = $signed({1'b0, focal_q}) * rz[NR];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= rv[NR];
    end
  end

  logic [NW-1:0] num3_q;
  always_ff @(posedge clk_i) begin
    m3_q    <= rrt[NR][MW-1:0];
    num3_q  <= num3;
  end

  logic [SbW-1:0] side_b [QuotW+1];
  always_ff @(posedge clk_i) begin
    side_b[0] <= {prod3, neg3, (rrt[NR][MW-1:0] == '0), pix3};
  end

  // ---------------- divider chain ----------------
  logic                dv   [QuotW+1];
  logic [DW-1:0]       drem [QuotW+1];
  logic [MW-1:0]       dden [QuotW+1];
  logic [QuotW-1:0]    dquo [QuotW+1];

  assign dv[0]   = v3_q;
  assign drem[0] = DW'(num3_q);
  assign dden[0] = m3_q;
  assign dquo[0] = '0;

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    cwm_div_cell #(
      .DW (DW),
      .MW (MW),
      .K  (QuotW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .rem_i   (drem[k]),
      .den_i   (dden[k]),
      .quo_i   (dquo[k]),
      .valid_o (dv[k+1]),
      .rem_o   (drem[k+1]),
      .den_o   (dden[k+1]),
      .quo_o   (dquo[k+1])
    );
    always_ff @(posedge clk_i) begin
      side_b[k+1] <= side_b[k];
    end
  end

  // ---------------- output stage ----------------
  logic [PW-1:0]        prod_o;
  logic                 neg_o, mz_o;
  logic [PixAll-1:0]    pix_o;
  logic signed [XoW-1:0] xoff;
  logic [QuotW:0]       ymag;
  logic signed [SumW-1:0] yoff, col_sum, row_sum;

  // side_b[QuotW] lines up with the last divider cell's output
  assign {prod_o, neg_o, mz_o, pix_o} = side_b[QuotW];

  function automatic logic [AddrW-1:0] clamp_coord(input logic signed [SumW-1:0] v,
                                                   input logic [DimW-1:0] size);
    logic signed [SumW-1:0] hi;
    hi = $signed(SumW'(size)) - SumW'(1);
    if (hi > CapV) hi = CapV;
    if (hi < 0) hi = '0;
    if (v < 0) return '0;
    if (v > hi) return hi[AddrW-1:0];
    return v[AddrW-1:0];
  endfunction

  // Negative rows round toward minus infinity: a nonzero remainder adds one to the magnitude.
  always_comb begin
    xoff = $signed(prod_o[PW-1:XSh]);
    ymag = {1'b0, dquo[QuotW]} + (QuotW+1)'(drem[QuotW] != '0);
    if (mz_o) begin
      yoff = '0;
    end else if (neg_o) begin
      yoff = -$signed(SumW'(ymag));
    end else begin
      yoff = $signed(SumW'(dquo[QuotW]));
    end
    col_sum = $signed(SumW'(whalf)) + SumW'(xoff);
    row_sum = $signed(SumW'(hhalf)) + yoff;
  end

  logic                 ov_q;
  logic [AddrW-1:0]     row_q, col_q;
  logic [PixAll-1:0]    pixo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= dv[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= clamp_coord(row_sum, height_q);
    col_q  <= clamp_coord(col_sum, width_q);
    pixo_q <= pix_o;
  end

  assign out_valid_o = ov_q;
  assign dst_row_o   = row_q;
  assign dst_col_o   = col_q;
  assign out_blue_o  = pixo_q[PixW-1:0];
  assign out_green_o = pixo_q[2*PixW-1:PixW];
  assign out_red_o   = pixo_q[3*PixW-1:2*PixW];

endmodule
`default_nettype wire

@@ hdl/cwm_checker.sv @@
// Port-level checks of the cylindrical warp and their binding to the top level.
`default_nettype none
module cwm_checker #(
  parameter int LAT = 38
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid_o,
  input logic [cwm_pkg::PixW-1:0]      pix_blue_i,
  input logic [cwm_pkg::PixW-1:0]      pix_red_i,
  input logic [cwm_pkg::PixW-1:0]      out_blue_o,
  input logic [cwm_pkg::PixW-1:0]      out_red_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT out_valid_o)
    else $error("accepted item did not come out");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, LAT))
    else $error("result without an item");

  a_pix_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_blue_o == $past(pix_blue_i, LAT)
                     && out_red_o == $past(pix_red_i, LAT)))
    else $error("pixel changed on its way");

endmodule

bind cylindrical_warp_mapping cwm_checker #(.LAT(38)) u_cwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .pix_blue_i  (pix_blue_i),
  .pix_red_i   (pix_red_i),
  .out_blue_o  (out_blue_o),
  .out_red_o   (out_red_o)
);
`default_nettype wire

@@ bench/cwm_checker.sv @@
// Checker for the cylindrical warp: follows config writes, predicts each destination, compares.
`default_nettype none
module cwm_scoreboard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cwm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cwm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         start,
  input  logic                         busy,
  input  logic [cwm_pkg::AddrW-1:0]    src_row_i,
  input  logic [cwm_pkg::AddrW-1:0]    src_col_i,
  input  logic [cwm_pkg::PixW-1:0]     pix_blue_i,
  input  logic [cwm_pkg::PixW-1:0]     pix_green_i,
  input  logic [cwm_pkg::PixW-1:0]     pix_red_i,
  input  logic                         out_valid_o,
  input  logic [cwm_pkg::AddrW-1:0]    dst_row_o,
  input  logic [cwm_pkg::AddrW-1:0]    dst_col_o,
  input  logic [cwm_pkg::PixW-1:0]     out_blue_o,
  input  logic [cwm_pkg::PixW-1:0]     out_green_o,
  input  logic [cwm_pkg::PixW-1:0]     out_red_o,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cwm_pkg::*;

  typedef struct {
    logic [AddrW-1:0] row;
    logic [AddrW-1:0] col;
    logic [PixW-1:0]  blue;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  red;
  } warped_pix_t;

  localparam longint ArcTab [16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                     262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                                     1024, 512};

  logic [DimW-1:0] img_w, img_h;
  logic [FocW-1:0] focal;
  warped_pix_t     warp_q[$];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w <= WidthRst;
      img_h <= HeightRst;
      focal <= FocalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  img_w <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: img_h <= cfg_data_i[DimW-1:0];
        CFG_FOCAL:  focal <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Clamp to [0, min(size-1, 4095)].
  function automatic logic [AddrW-1:0] clamp_dst(longint v, longint size);
    longint hi;
    hi = size - 1;
    if (hi > 4095) hi = 4095;
    if (hi < 0) hi = 0;
    if (v < 0) return '0;
    if (v > hi) return hi[AddrW-1:0];
    return v[AddrW-1:0];
  endfunction

  function automatic warped_pix_t warp_pixel(logic [AddrW-1:0] row, logic [AddrW-1:0] col,
                                             logic [PixW-1:0] b, logic [PixW-1:0] g,
                                             logic [PixW-1:0] r);
    warped_pix_t res;
    longint whalf, hhalf, f, xp, yp, cx, cy, z, dx, dy, xoff, yoff, m, num;
    whalf = longint'(img_w >> 1);
    hhalf = longint'(img_h >> 1);
    f  = longint'(focal);
    xp = longint'(col) - whalf;
    yp = longint'(row) - hhalf;
    cx = f * 256;
    cy = xp * 65536;
    z  = 0;
    // vectoring CORDIC, floor shifts
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ArcTab[i];
      end else begin
        cx -= dx; cy += dy; z -= ArcTab[i];
      end
    end
    xoff = (f * z) >>> 32;
    m = root_floor(longint'(xp * xp) * 65536 + f * f);
    if (m == 0) yoff = 0;
    else begin
      num = f * yp;
      yoff = (num >= 0) ? num / m : -((-num + m - 1) / m);
    end
    res.row   = clamp_dst(hhalf + yoff, longint'(img_h));
    res.col   = clamp_dst(whalf + xoff, longint'(img_w));
    res.blue  = b;
    res.green = g;
    res.red   = r;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    checked_o = 0;
  end

  assign pending_o = warp_q.size();

  always @(posedge clk_i) begin
    warped_pix_t want;
    if (rst_ni) begin
      if (out_valid_o) begin
        if (warp_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = warp_q.pop_front();
          checked_o++;
          if (dst_row_o !== want.row)     report("dst_row", dst_row_o, want.row);
          if (dst_col_o !== want.col)     report("dst_col", dst_col_o, want.col);
          if (out_blue_o !== want.blue)   report("out_blue", out_blue_o, want.blue);
          if (out_green_o !== want.green) report("out_green", out_green_o, want.green);
          if (out_red_o !== want.red)     report("out_red", out_red_o, want.red);
        end
      end
      if (start && !busy)
        warp_q = {warp_q, warp_pixel(src_row_i, src_col_i, pix_blue_i, pix_green_i,
                                     pix_red_i)};
    end
  end
endmodule
`default_nettype wire

@@ bench/cylindrical_warp_mapping_tb.sv @@
// Testbench top: stimulus, config phases and verdict for the cylindrical warp.
`default_nettype none
module cylindrical_warp_mapping_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwm_pkg::*;

  localparam int SettleCycles = 60;      // longer than the pipeline is deep
  localparam int CycleLimit   = 200000;  // bound for ~1820 items sent with gaps

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [AddrW-1:0]    src_row_i = '0, src_col_i = '0;
  logic [PixW-1:0]     pix_blue_i = '0, pix_green_i = '0, pix_red_i = '0;
  logic                out_valid_o;
  logic [AddrW-1:0]    dst_row_o, dst_col_o;
  logic [PixW-1:0]     out_blue_o, out_green_o, out_red_o;
  int                  mismatches, pending, checked;
  int                  cycles = 0;
  int                  pixels_sent = 0;
  int                  phases_run = 0;
  bit                  calm_tail = 0;   // no idling near the end

  always #10 clk_i = ~clk_i;

  cylindrical_warp_mapping dut (.*);

  cwm_scoreboard chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .src_row_i, .src_col_i, .pix_blue_i, .pix_green_i, .pix_red_i,
    .out_valid_o, .dst_row_o, .dst_col_o, .out_blue_o, .out_green_o, .out_red_o,
    .mismatches_o(mismatches), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items still outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that took the item, start still high.
  task automatic send_pixel(int row, int col);
    bit taken;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start       <= 1'b1;
    src_row_i   <= row[AddrW-1:0];
    src_col_i   <= col[AddrW-1:0];
    pix_blue_i  <= PixW'($urandom);
    pix_green_i <= PixW'($urandom);
    pix_red_i   <= PixW'($urandom);
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    pixels_sent++;
  endtask

  // Drain the pipeline, then write all three registers.
  task automatic set_geometry(int w, int h, int f);
    start <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_WIDTH;  cfg_data_i <= CfgDataW'(w);
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= CfgDataW'(h);
    @(posedge clk_i);
    cfg_idx_i <= CFG_FOCAL;  cfg_data_i <= CfgDataW'(f);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phases_run++;
  endtask

  // Mostly inside the image, some anywhere in the 12-bit range (all when a side is under 2).
  task automatic random_pixels(int count, int w, int h);
    int r, c;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0 || w < 2 || h < 2) begin
        r = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095);
      end else begin
        r = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
        c = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
      end
      send_pixel(r, c);
    end
  endtask

  int geo_w [8] = '{640,  1,   4096,    0, 8191, 320, 1920, 100};
  int geo_h [8] = '{480,  1,   4096,    0, 8191, 240, 1080, 4000};
  int geo_f [8] = '{180224, 256, 1048575, 0, 1, 65536, 307200, 512000};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, centre and edges at reset geometry, then focal zero, then zero size.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(240, 320);
    send_pixel(240, 0);
    send_pixel(0, 320);
    send_pixel(479, 639);
    send_pixel(480, 640);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(2730, 1365);
    set_geometry(640, 480, 0);      // zero focal: column and row are both the centre
    send_pixel(240, 320);
    send_pixel(0, 320);
    send_pixel(4095, 0);
    send_pixel(100, 4095);
    set_geometry(0, 0, 180224);     // zero size: both fields pinned at 0
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1234, 3210);

    // Random phases across the geometry table, extremes among them.
    foreach (geo_w[p]) begin
      set_geometry(geo_w[p], geo_h[p], geo_f[p]);
      random_pixels(200, geo_w[p], geo_h[p]);
    end
    set_geometry($urandom_range(1, 8191), $urandom_range(1, 8191), $urandom_range(0, 1048575));
    calm_tail = 1;
    random_pixels(200, 4096, 4096);
    start <= 1'b0;

    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d pixels over %0d register settings, %0d destinations compared",
             pixels_sent, phases_run, checked);
    $display("settings spanned zero and full-scale size and focal length");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/cwm_pkg.sv
hdl/cwm_rot_cell.sv
hdl/cwm_div_cell.sv
hdl/cylindrical_warp_mapping.sv
hdl/cwm_checker.sv
bench/cwm_checker.sv
bench/cylindrical_warp_mapping_tb.sv
